// ===== rtl/core/snrd_pkg.sv =====
// Package for the smooth noise-robust differentiator: widths, coefficients, control types.
`default_nettype none

package snrd_pkg;

  // Fixed payload geometry
  localparam int Channels  = 4;
  localparam int SampleW   = 16;
  localparam int SlopeW    = 32;
  localparam int RateW     = 20;
  localparam logic [RateW-1:0] RateReset = 20'd1000;

  // Default window length (odd, 5..15)
  localparam int WindowDef = 7;
  localparam int MaxBinomN = 16;

  // Pipeline control handed from the merge stage to every lane
  typedef struct packed {
    logic en;    // all pipeline stages advance
    logic fire;  // an input transaction is taken this cycle
  } snrd_ctrl_t;

  // Binomial coefficient by Pascal's triangle; zero outside 0..n
  function automatic int binom(input int n, input int j);
    int row [MaxBinomN+1];
    int res;
    for (int x = 0; x <= MaxBinomN; x++) begin
      row[x] = (x == 0) ? 1 : 0;
    end
    for (int i = 1; i <= MaxBinomN; i++) begin
      if (i <= n) begin
        for (int x = MaxBinomN; x >= 1; x--) begin
          row[x] = row[x] + row[x-1];
        end
      end
    end
    if (j < 0 || j > n) begin
      res = 0;
    end else begin
      res = row[j];
    end
    return res;
  endfunction

  // Tap weight for the difference k steps either side of the center
  function automatic int coef(input int window, input int k);
    int m;
    m = (window - 3) >> 1;
    return binom(2 * m, m - k + 1) - binom(2 * m, m - k - 1);
  endfunction

  // Sum of all tap weights (all are positive)
  function automatic int coef_total(input int window);
    int half;
    int acc;
    half = (window - 1) >> 1;
    acc  = 0;
    for (int k = 1; k <= half; k++) begin
      acc = acc + coef(window, k);
    end
    return acc;
  endfunction

  // Width of the weighted difference sum (signed)
  function automatic int sum_width(input int window);
    return SampleW + 2 + $clog2(coef_total(window));
  endfunction

  // Width of sum times gain (signed)
  function automatic int prod_width(input int window);
    return sum_width(window) + RateW + 1;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/snrd_in_if.sv =====
// Input channel: one vector of channel samples with valid/ready.
`default_nettype none

interface snrd_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [snrd_pkg::SampleW-1:0]    sample_0;
  logic signed [snrd_pkg::SampleW-1:0]    sample_1;
  logic signed [snrd_pkg::SampleW-1:0]    sample_2;
  logic signed [snrd_pkg::SampleW-1:0]    sample_3;

  modport source (output valid, sample_0, sample_1, sample_2, sample_3, input ready);
  modport sink   (input valid, sample_0, sample_1, sample_2, sample_3, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/snrd_out_if.sv =====
// Output channel: one vector of channel slopes with valid/ready.
`default_nettype none

interface snrd_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [snrd_pkg::SlopeW-1:0]     slope_0;
  logic signed [snrd_pkg::SlopeW-1:0]     slope_1;
  logic signed [snrd_pkg::SlopeW-1:0]     slope_2;
  logic signed [snrd_pkg::SlopeW-1:0]     slope_3;

  modport source (output valid, slope_0, slope_1, slope_2, slope_3, input ready);
  modport sink   (input valid, slope_0, slope_1, slope_2, slope_3, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/snrd_lane.sv =====
// One channel lane: sample history, weighted difference sum and gain multiply.
`default_nettype none

module snrd_lane #(
  parameter int WINDOW = snrd_pkg::WindowDef
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        rst_ni,
  input  wire snrd_pkg::snrd_ctrl_t                        ctrl_i,
  input  wire logic signed [snrd_pkg::SampleW-1:0]         sample_i,
  input  wire logic [snrd_pkg::RateW-1:0]                  rate_i,
  output logic signed [snrd_pkg::prod_width(WINDOW)-1:0]   prod_o
);

  localparam int Half    = (WINDOW - 1) / 2;
  localparam int HDepth  = WINDOW - 1;
  localparam int SumW    = snrd_pkg::sum_width(WINDOW);
  localparam int ProdW   = snrd_pkg::prod_width(WINDOW);
  localparam int RateW_S = snrd_pkg::RateW + 1;

  logic signed [snrd_pkg::SampleW-1:0] hist_q [HDepth];
  logic signed [snrd_pkg::SampleW-1:0] win    [WINDOW];
  logic signed [SumW-1:0]              sum_d, sum_q;
  logic signed [RateW_S-1:0]           rate_s;
  logic signed [ProdW-1:0]             prod_d, prod_q;

  // Window: newest sample first, then history oldest last
  always_comb begin
    win[0] = sample_i;
    for (int d = 1; d < WINDOW; d++) begin
      win[d] = hist_q[d-1];
    end
  end

  // History shift line, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int d = 0; d < HDepth; d++) begin
        hist_q[d] <= '0;
      end
    end else if (ctrl_i.fire) begin
      hist_q[0] <= sample_i;
      for (int d = 1; d < HDepth; d++) begin
        hist_q[d] <= hist_q[d-1];
      end
    end
  end

  // Weighted central differences around the window center
  always_comb begin
    sum_d = '0;
    for (int k = 1; k <= Half; k++) begin
      sum_d = sum_d + SumW'(snrd_pkg::coef(WINDOW, k))
                      * (SumW'(win[Half-k]) - SumW'(win[Half+k]));
    end
  end

  // Gain multiply on the registered sum
  assign rate_s = $signed({1'b0, rate_i});
  assign prod_d = ProdW'(sum_q) * ProdW'(rate_s);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      sum_q  <= sum_d;
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// ===== rtl/core/snrd_merge.sv =====
// Merge stage: pipeline control, floor shift and saturation of all lanes, output register.
`default_nettype none

module snrd_merge #(
  parameter int WINDOW = snrd_pkg::WindowDef
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        rst_ni,
  input  wire logic                                        in_valid_i,
  output logic                                             in_ready_o,
  output snrd_pkg::snrd_ctrl_t                             ctrl_o,
  input  wire logic signed [snrd_pkg::prod_width(WINDOW)-1:0] prod_i [snrd_pkg::Channels],
  snrd_out_if.source                                       out_o
);

  localparam int ProdW = snrd_pkg::prod_width(WINDOW);
  localparam int Shift = WINDOW - 2;
  localparam int SlW   = snrd_pkg::SlopeW;

  logic en;
  logic sum_vld_q, prod_vld_q, out_vld_q;
  logic signed [ProdW-1:0] shr   [snrd_pkg::Channels];
  logic signed [SlW-1:0]   sat_d [snrd_pkg::Channels];
  logic signed [SlW-1:0]   slope_q [snrd_pkg::Channels];

  // Whole pipeline moves when the output register is free or drained
  assign en          = !out_vld_q || out_o.ready;
  assign in_ready_o  = en;
  assign ctrl_o.en   = en;
  assign ctrl_o.fire = in_valid_i && en;

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_vld_q  <= 1'b0;
      prod_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else if (en) begin
      sum_vld_q  <= ctrl_o.fire;
      prod_vld_q <= sum_vld_q;
      out_vld_q  <= prod_vld_q;
    end
  end

  // Floor shift and clamp to signed 32 bits per lane
  always_comb begin
    for (int c = 0; c < snrd_pkg::Channels; c++) begin
      shr[c] = prod_i[c] >>> Shift;
      if (!shr[c][ProdW-1] && (|shr[c][ProdW-2:SlW-1])) begin
        sat_d[c] = {1'b0, {(SlW-1){1'b1}}};
      end else if (shr[c][ProdW-1] && !(&shr[c][ProdW-2:SlW-1])) begin
        sat_d[c] = {1'b1, {(SlW-1){1'b0}}};
      end else begin
        sat_d[c] = shr[c][SlW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < snrd_pkg::Channels; c++) begin
        slope_q[c] <= sat_d[c];
      end
    end
  end

  assign out_o.valid   = out_vld_q;
  assign out_o.slope_0 = slope_q[0];
  assign out_o.slope_1 = slope_q[1];
  assign out_o.slope_2 = slope_q[2];
  assign out_o.slope_3 = slope_q[3];

endmodule

`default_nettype wire

// ===== rtl/core/smooth_noise_robust_differentiator.sv =====
// Top level of the smooth noise-robust differentiator.
`default_nettype none

// Takes one vector of four signed 16-bit samples per transaction and returns, per channel,
// the smooth noise-robust derivative at the window center (WINDOW-1)/2 samples back, scaled
// by the sample-rate register, floor-shifted right by WINDOW-2 and saturated to signed 32
// bits. One vector is accepted every cycle unless the output stalls; each result passes
// the sum, multiplier and output registers in turn, and the whole pipeline stalls
// together only while a finished result waits on the output. Each channel has its own lane
// with a WINDOW-1 deep history shift line that reset clears to zero, so missing start-up
// samples count as zero. sample_rate is written through cfg_we_i/cfg_data_i, resets to 1000,
// and must only change while no transaction is in flight.

module smooth_noise_robust_differentiator #(
  parameter int WINDOW = snrd_pkg::WindowDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [snrd_pkg::RateW-1:0]    cfg_data_i,
  snrd_in_if.sink                            in_i,
  snrd_out_if.source                         out_o
);

  localparam int ProdW = snrd_pkg::prod_width(WINDOW);

  logic [snrd_pkg::RateW-1:0]           rate_q;
  snrd_pkg::snrd_ctrl_t                 ctrl;
  logic signed [snrd_pkg::SampleW-1:0]  samp [snrd_pkg::Channels];
  logic signed [ProdW-1:0]              prod [snrd_pkg::Channels];

  // Gain register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= snrd_pkg::RateReset;
    end else if (cfg_we_i) begin
      rate_q <= cfg_data_i;
    end
  end

  assign samp[0] = in_i.sample_0;
  assign samp[1] = in_i.sample_1;
  assign samp[2] = in_i.sample_2;
  assign samp[3] = in_i.sample_3;

  // One lane per channel
  for (genvar c = 0; c < snrd_pkg::Channels; c++) begin : g_lane
    snrd_lane #(
      .WINDOW (WINDOW)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .sample_i (samp[c]),
      .rate_i   (rate_q),
      .prod_o   (prod[c])
    );
  end

  // Combine lanes, drive the output channel
  snrd_merge #(
    .WINDOW (WINDOW)
  ) u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .ctrl_o     (ctrl),
    .prod_i     (prod),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/snrd_checker.sv =====
// Port-level checker for the differentiator, bound to the top level.
`default_nettype none

module snrd_checker (
  input wire logic                                  clk_i,
  input wire logic                                  rst_ni,
  input wire logic                                  in_valid_i,
  input wire logic                                  in_ready_i,
  input wire logic                                  out_valid_i,
  input wire logic                                  out_ready_i,
  input wire logic signed [snrd_pkg::SlopeW-1:0]    slope_0_i
);

  logic in_fire;
  assign in_fire = in_valid_i && in_ready_i;

  // Stalled result keeps its valid and slope_0
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(slope_0_i))
    else $error("stalled output transaction changed");

  // Input is taken exactly when the output side can move
  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (!out_valid_i || out_ready_i))
    else $error("input ready does not follow output backpressure");

  // Accepted vector reaches the output when the output drains in between
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire ##1 out_ready_i ##1 out_ready_i |=> out_valid_i)
    else $error("result missing three cycles after input transaction");

  // No result appears without an input
  a_no_ghost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_fire && out_ready_i) ##1 (!in_fire && out_ready_i) ##1 (!in_fire && out_ready_i)
    |=> !out_valid_i)
    else $error("output transaction without matching input");

endmodule

bind smooth_noise_robust_differentiator snrd_checker u_snrd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .slope_0_i   (out_o.slope_0)
);

`default_nettype wire

// ===== verif/snrd_slope_checker.sv =====
// Checker for the differentiator: mirrors the sample windows, predicts and compares slope vectors.
module snrd_slope_checker #(
  parameter int WINDOW = snrd_pkg::WindowDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [snrd_pkg::RateW-1:0] cfg_data_i,
  snrd_in_if                         in_w,
  snrd_out_if                        out_w,
  output int                         errors_o,
  output int                         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Channels  = snrd_pkg::Channels;
  localparam int SampleW   = snrd_pkg::SampleW;
  localparam int SlopeW    = snrd_pkg::SlopeW;
  localparam int RateW     = snrd_pkg::RateW;
  localparam int Half      = (WINDOW - 1) / 2;
  localparam int Depth     = WINDOW - 1;
  localparam int Shift     = WINDOW - 2;
  localparam int FifoDepth = 16;
  localparam longint SlopeMax = 64'sd2147483647;
  localparam longint SlopeMin = -64'sd2147483648;

  typedef logic [Channels-1:0][SampleW-1:0] sample_set_t;
  typedef logic [Channels-1:0][SlopeW-1:0]  slope_set_t;

  logic [RateW-1:0]          gain;
  logic signed [SampleW-1:0] hist [Channels][Depth];
  slope_set_t                expected_slopes [FifoDepth];
  int                        head_idx = 0;
  int                        tail_idx = 0;
  int                        fill = 0;
  int                        fail_count = 0;

  assign errors_o  = fail_count;
  assign pending_o = fill;

  // n choose j, zero outside 0..n
  function automatic longint choose(input int n, input int j);
    longint r = 1;
    if (j < 0 || j > n) return 0;
    for (int i = 1; i <= j; i++) begin
      r = r * (n + 1 - i) / i;
    end
    return r;
  endfunction

  // Weight of the difference k samples either side of the center
  function automatic longint tap_weight(input int k);
    int m;
    m = (WINDOW - 3) / 2;
    return choose(2 * m, m - k + 1) - choose(2 * m, m - k - 1);
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns snrd_slope_checker: %s", $time, what);
    fail_count++;
  endtask

  // Slope of every channel for the window ending at fresh; then shift fresh into history
  task automatic advance_window(input sample_set_t fresh, output slope_set_t slopes);
    longint win [WINDOW];
    longint acc;
    longint scaled;
    for (int ch = 0; ch < Channels; ch++) begin
      win[0] = longint'($signed(fresh[ch]));
      for (int d = 1; d < WINDOW; d++) begin
        win[d] = longint'(hist[ch][d-1]);
      end
      acc = 0;
      for (int k = 1; k <= Half; k++) begin
        acc += tap_weight(k) * (win[Half-k] - win[Half+k]);
      end
      // arithmetic shift floors toward minus infinity
      scaled = (acc * longint'(gain)) >>> Shift;
      if (scaled > SlopeMax) scaled = SlopeMax;
      if (scaled < SlopeMin) scaled = SlopeMin;
      slopes[ch] = scaled[SlopeW-1:0];
      for (int d = Depth - 1; d > 0; d--) begin
        hist[ch][d] = hist[ch][d-1];
      end
      hist[ch][0] = fresh[ch];
    end
  endtask

  // Watch both channels and the register port on every edge
  always @(posedge clk_i) begin : watch
    slope_set_t  got;
    slope_set_t  want;
    sample_set_t fresh;
    if (!rst_ni) begin
      gain = snrd_pkg::RateReset;
      for (int ch = 0; ch < Channels; ch++) begin
        for (int d = 0; d < Depth; d++) begin
          hist[ch][d] = '0;
        end
      end
      head_idx = 0;
      tail_idx = 0;
      fill     = 0;
    end else begin
      // result transaction
      if (out_w.valid && out_w.ready) begin
        got = {out_w.slope_3, out_w.slope_2, out_w.slope_1, out_w.slope_0};
        if (fill == 0) begin
          report_mismatch("slope vector with no sample vector pending");
        end else begin
          want     = expected_slopes[head_idx];
          head_idx = (head_idx + 1) % FifoDepth;
          fill--;
          for (int ch = 0; ch < Channels; ch++) begin
            if (got[ch] !== want[ch]) begin
              report_mismatch($sformatf("slope_%0d got %0d expected %0d", ch,
                                        $signed(got[ch]), $signed(want[ch])));
            end
          end
        end
      end
      // sample transaction
      if (in_w.valid && in_w.ready) begin
        fresh = {in_w.sample_3, in_w.sample_2, in_w.sample_1, in_w.sample_0};
        advance_window(fresh, want);
        if (fill == FifoDepth) begin
          report_mismatch("too many sample vectors in flight");
        end else begin
          expected_slopes[tail_idx] = want;
          tail_idx = (tail_idx + 1) % FifoDepth;
          fill++;
        end
      end
      // gain register write
      if (cfg_we_i) begin
        gain = cfg_data_i;
      end
    end
  end

endmodule

// ===== verif/tb_smooth_noise_robust_differentiator.sv =====
// Testbench top for the differentiator: clock, reset, stimulus, handshake pacing and verdict.
module tb_smooth_noise_robust_differentiator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Channels = snrd_pkg::Channels;
  localparam int SampleW  = snrd_pkg::SampleW;
  localparam int RateW    = snrd_pkg::RateW;

  typedef logic [Channels-1:0][SampleW-1:0] sample_set_t;

  localparam logic [RateW-1:0] GainMax = {RateW{1'b1}};
  localparam logic [RateW-1:0] GainOff = '0;
  localparam logic [RateW-1:0] GainMin = 20'd1;
  localparam int SegItems = 80;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [RateW-1:0] cfg_data;
  int               in_idle_pct;
  int               out_idle_pct;
  int               errors;
  int               pending;
  int               level [Channels];
  int               ramp_step [Channels];

  snrd_in_if  in_w ();
  snrd_out_if out_w ();

  smooth_noise_robust_differentiator dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .in_i       (in_w),
    .out_o      (out_w)
  );

  snrd_slope_checker checker_i (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .in_w       (in_w),
    .out_w      (out_w),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver back-pressure
  initial begin
    out_w.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_w.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Run limit
  initial begin
    #400_000;
    $display("tb_smooth_noise_robust_differentiator: done, errors");
    $finish;
  end

  function automatic logic [SampleW-1:0] clamp16(input int x);
    if (x > 32767) x = 32767;
    if (x < -32768) x = -32768;
    return SampleW'(x);
  endfunction

  // Random vector: full-range values, ramps, noise and holds on a running level, and rail values
  function automatic sample_set_t next_random();
    sample_set_t v;
    int          shape;
    for (int ch = 0; ch < Channels; ch++) begin
      shape = $urandom_range(9);
      if ($urandom_range(7) == 0) ramp_step[ch] = int'($urandom_range(8000)) - 4000;
      case (shape)
        0, 1, 2, 3: v[ch] = SampleW'($urandom);
        4, 5, 6:    v[ch] = clamp16(level[ch] + ramp_step[ch]);
        7:          v[ch] = $urandom_range(1) ? 16'h7fff : 16'h8000;
        8:          v[ch] = clamp16(level[ch] + int'($urandom_range(6)) - 3);
        default:    v[ch] = SampleW'(level[ch]);
      endcase
    end
    return v;
  endfunction

  // One sample transaction, with random idle cycles ahead of it
  task automatic send_vec(input sample_set_t v);
    while ($urandom_range(99) < in_idle_pct) begin
      in_w.valid <= 1'b0;
      @(posedge clk);
    end
    in_w.valid    <= 1'b1;
    in_w.sample_0 <= v[0];
    in_w.sample_1 <= v[1];
    in_w.sample_2 <= v[2];
    in_w.sample_3 <= v[3];
    for (int ch = 0; ch < Channels; ch++) begin
      level[ch] = int'($signed(v[ch]));
    end
    do @(posedge clk); while (!in_w.ready);
  endtask

  task automatic run_random(input int n);
    repeat (n) send_vec(next_random());
  endtask

  // Stop sending and wait until every expected slope vector has come back
  task automatic drain();
    in_w.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_gain(input logic [RateW-1:0] value);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_data      <= '0;
    in_w.valid    <= 1'b0;
    in_w.sample_0 <= '0;
    in_w.sample_1 <= '0;
    in_w.sample_2 <= '0;
    in_w.sample_3 <= '0;
    in_idle_pct  = 24;
    out_idle_pct = 82;
    for (int ch = 0; ch < Channels; ch++) begin
      level[ch]     = 0;
      ramp_step[ch] = 0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset gain: rails, bit patterns, alternation, return to zero
    repeat (3) send_vec({16'h0001, 16'h5555, 16'h8000, 16'h7fff});
    repeat (3) send_vec({16'hffff, 16'haaaa, 16'h7fff, 16'h8000});
    repeat (2) begin
      send_vec({16'h0001, 16'h7fff, 16'h8000, 16'h7fff});
      send_vec({16'hffff, 16'h8000, 16'h7fff, 16'h8000});
    end
    repeat (3) send_vec('0);

    // Directed, full gain: opposite steps saturate both ways, small odd values floor
    write_gain(GainMax);
    repeat (3) send_vec({16'h0001, 16'h0000, 16'h7fff, 16'h8000});
    repeat (3) send_vec({16'hfffe, 16'h0000, 16'h8000, 16'h7fff});
    send_vec({16'h0001, 16'hffff, 16'h8000, 16'h7fff});
    send_vec({16'hfffe, 16'h0001, 16'h7fff, 16'h8000});

    // Sender idles lightly, receiver heavily
    write_gain(GainOff);
    run_random(SegItems);
    write_gain(RateW'($urandom_range(1048575, 1)));
    run_random(SegItems);

    // Sender idles heavily, receiver lightly
    drain();
    in_idle_pct  = 82;
    out_idle_pct = 24;
    write_gain(GainMin);
    run_random(SegItems);
    write_gain(GainMax);
    run_random(SegItems);

    // No idling on either side
    drain();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    write_gain(RateW'($urandom_range(4095, 1)));
    run_random(SegItems);
    write_gain(snrd_pkg::RateReset);
    run_random(SegItems);

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("tb_smooth_noise_robust_differentiator: done, clean");
    end else begin
      $display("tb_smooth_noise_robust_differentiator: done, errors");
    end
    $finish;
  end

endmodule
